// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
// expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge out of reset
`define AVGP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define AVGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/avgp_pkg.sv =====
// shared types and constants of the 3x3 stride 2 average pooling core
// no dependencies
`default_nettype none

package avgp_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int NUM_SLOTS = 4;
    localparam int REC_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAD_ROWS   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PAD_COLS   = 3'd5;

    typedef struct packed {
        logic [10:0] rows_in;
        logic [10:0] cols_in;
        logic [9:0]  rows_out;
        logic [9:0]  cols_out;
        logic [1:0]  pad_rows;
        logic [1:0]  pad_cols;
    } t_cfg;

    // slot order: (upper row, left window), (upper row, right window),
    // (lower row, left window), (lower row, right window)
    typedef struct packed {
        logic [NUM_SLOTS-1:0] valid;
        logic [NUM_SLOTS-1:0] emit;
        logic [NUM_SLOTS-1:0] first;
        logic [NUM_SLOTS-1:0] done;
        logic [NUM_SLOTS-1:0] last;
        logic                 bank0;
    } t_slots;

endpackage

`default_nettype wire

// ===== sv/avg_pool_3x3_stride2_core.sv =====
// top level of the 3x3 stride 2 average pooling core
// depends on avgp_pkg, avgp_front, avgp_queue, avgp_back
//
// port group     direction   handshake                 word
// sample in      in          push / full               i_sample
// result out     out         pop / empty               o_average, o_plane_done, o_run_last
// config         in/out      psel penable pwrite pready paddr, pwdata, prdata
//
// one sample per cycle while the record queue is not full; window updates are issued to the
// accumulator memory one at a time, so a sample that closes more than one window row segment
// holds the back end until they are all issued; a result word passes the record queue, the
// record register and the read, accumulate and divide stages, behind each update queued ahead of it
// synchronous active-low reset loads the default config and clears position, queues and pipeline valids
// the accumulator memory needs no clearing: each entry is loaded by its window's first row
`default_nettype none

module avg_pool_3x3_stride2_core #(
    parameter int MAX_WIDTH   = avgp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = avgp_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [SAMPLE_BITS-1:0]      o_average,
    output logic                               o_plane_done,
    output logic                               o_run_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [avgp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import avgp_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH / 2 + 1);
    localparam int HW = SAMPLE_BITS + 2;
    localparam int SW = $bits(t_slots);
    localparam int RECW = SW + 2 * HW + AW;

    t_cfg                  r_cfg;
    logic                  w_wr, w_cfg_wr, w_accept;
    logic [REG_IDX_W-1:0]  w_idx;

    t_slots                w_slots, w_q_slots;
    logic signed [HW-1:0]  w_seg_a, w_seg_b;
    logic [AW-1:0]         w_ow_b;
    logic                  w_rec_push, w_rec_pop, w_rec_empty;
    logic [RECW-1:0]       w_rec_in, w_rec_out;
    logic [$clog2(REC_DEPTH+1)-1:0] w_rec_cnt;

    assign pready   = 1'b1;
    assign w_idx    = paddr[REG_IDX_W+1:2];
    assign w_wr     = psel && penable && pwrite && pready;
    assign w_accept = push && !full;

    always_comb begin
        w_cfg_wr = 1'b0;
        prdata   = '0;
        unique case (w_idx)
            REG_IN_HEIGHT: begin
                w_cfg_wr = w_wr;
                prdata   = 32'(r_cfg.rows_in);
            end
            REG_IN_WIDTH: begin
                w_cfg_wr = w_wr;
                prdata   = 32'(r_cfg.cols_in);
            end
            REG_OUT_HEIGHT: begin
                w_cfg_wr = w_wr;
                prdata   = 32'(r_cfg.rows_out);
            end
            REG_OUT_WIDTH: begin
                w_cfg_wr = w_wr;
                prdata   = 32'(r_cfg.cols_out);
            end
            REG_PAD_ROWS: begin
                w_cfg_wr = w_wr;
                prdata   = 32'(r_cfg.pad_rows);
            end
            REG_PAD_COLS: begin
                w_cfg_wr = w_wr;
                prdata   = 32'(r_cfg.pad_cols);
            end
            default: begin
                w_cfg_wr = 1'b0;
                prdata   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_in  <= 11'd1;
            r_cfg.cols_in  <= 11'd1;
            r_cfg.rows_out <= 10'd1;
            r_cfg.cols_out <= 10'd1;
            r_cfg.pad_rows <= 2'd0;
            r_cfg.pad_cols <= 2'd0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_IN_HEIGHT:  r_cfg.rows_in  <= pwdata[10:0];
                REG_IN_WIDTH:   r_cfg.cols_in  <= pwdata[10:0];
                REG_OUT_HEIGHT: r_cfg.rows_out <= pwdata[9:0];
                REG_OUT_WIDTH:  r_cfg.cols_out <= pwdata[9:0];
                REG_PAD_ROWS:   r_cfg.pad_rows <= pwdata[1:0];
                REG_PAD_COLS:   r_cfg.pad_cols <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    avgp_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cfg_wr   (w_cfg_wr),
        .i_accept   (w_accept),
        .i_sample   (i_sample),
        .o_rec_push (w_rec_push),
        .o_slots    (w_slots),
        .o_seg_a    (w_seg_a),
        .o_seg_b    (w_seg_b),
        .o_ow_b     (w_ow_b)
    );

    assign w_rec_in = {w_slots, w_seg_a, w_seg_b, w_ow_b};

    avgp_queue #(
        .WIDTH (RECW),
        .DEPTH (REC_DEPTH)
    ) u_recq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_data  (w_rec_in),
        .o_full  (full),
        .i_pop   (w_rec_pop),
        .o_empty (w_rec_empty),
        .o_data  (w_rec_out),
        .o_count (w_rec_cnt)
    );

    assign w_q_slots = w_rec_out[RECW-1 -: SW];

    avgp_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (!w_rec_empty && w_rec_cnt != '0),
        .i_slots      (w_q_slots),
        .i_seg_a      (w_rec_out[AW+2*HW-1 -: HW]),
        .i_seg_b      (w_rec_out[AW+HW-1 -: HW]),
        .i_ow_b       (w_rec_out[AW-1:0]),
        .o_rec_pop    (w_rec_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_average    (o_average),
        .o_plane_done (o_plane_done),
        .o_run_last   (o_run_last)
    );

endmodule

`default_nettype wire

// ===== sv/avgp_queue.sv =====
// small register queue with occupancy count
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module avgp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [WIDTH-1:0]               o_data,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `AVGP_ASSERT_ALWAYS(a_cnt_range, r_cnt <= CW'(DEPTH), "queue count beyond depth")
    `AVGP_ASSERT_ALWAYS(a_no_overflow, !(i_push && o_full), "word pushed into full queue")
    `AVGP_ASSERT_NEXT(a_cnt_down, w_rd && !w_wr, r_cnt == $past(r_cnt) - CW'(1), "count lost on read")
    `AVGP_ASSERT_NEXT(a_cnt_up, w_wr && !w_rd, r_cnt == $past(r_cnt) + CW'(1), "count lost")

endmodule

`default_nettype wire

// ===== sv/avgp_front.sv =====
// front end: plane position, horizontal window sums, window classification
// depends on avgp_pkg
`default_nettype none

module avgp_front #(
    parameter int MAX_WIDTH   = avgp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = avgp_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  avgp_pkg::t_cfg                        i_cfg,
    input  logic                                  i_cfg_wr,
    input  logic                                  i_accept,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic                                  o_rec_push,
    output avgp_pkg::t_slots                      o_slots,
    output logic signed [SAMPLE_BITS+1:0]         o_seg_a,
    output logic signed [SAMPLE_BITS+1:0]         o_seg_b,
    output logic [$clog2(MAX_WIDTH/2+1)-1:0]      o_ow_b
);
    import avgp_pkg::*;

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int ACC_COLS = MAX_WIDTH / 2 + 1;
    localparam int OH_MAX   = MAX_HEIGHT / 2 + 1;
    localparam int AW       = $clog2(ACC_COLS);
    localparam int HW       = SAMPLE_BITS + 2;

    logic [CW-1:0]        r_col, n_col;
    logic [RW-1:0]        r_row, n_row;
    logic signed [HW-1:0] r_hp, n_hp;

    logic [CW-1:0]        w_last;
    logic [RW-1:0]        h_last;
    logic [CW:0]          ow_lim, t_c;
    logic [RW:0]          oh_lim, t_r;
    logic [CW-1:0]        ow1;
    logic [RW-1:0]        oh1;
    logic                 c_even, r_even;
    logic                 a_ok, b_ok, oh0_ok, oh1_ok;
    logic                 oh1_first, oh1_emit;
    logic                 done_ra, done_rb, done_ca, done_cb;
    logic signed [HW-1:0] s_ext;
    logic [3:0]           em;

    // effective sizes
    always_comb begin
        if (i_cfg.cols_in == '0) begin
            w_last = '0;
        end else if (32'(i_cfg.cols_in) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(i_cfg.cols_in - 11'd1);
        end
        if (i_cfg.rows_in == '0) begin
            h_last = '0;
        end else if (32'(i_cfg.rows_in) > MAX_HEIGHT) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(i_cfg.rows_in - 11'd1);
        end
        ow_lim = (32'(i_cfg.cols_out) > ACC_COLS) ? (CW+1)'(ACC_COLS)
                                                  : (CW+1)'(i_cfg.cols_out);
        oh_lim = (32'(i_cfg.rows_out) > OH_MAX) ? (RW+1)'(OH_MAX)
                                                : (RW+1)'(i_cfg.rows_out);
    end

    assign s_ext = HW'(i_sample);

    always_comb begin
        t_c    = {1'b0, r_col} + (CW+1)'(i_cfg.pad_cols[1]);
        ow1    = t_c[CW:1];
        c_even = ~t_c[0];
        t_r    = {1'b0, r_row} + (RW+1)'(i_cfg.pad_rows[1]);
        oh1    = t_r[RW:1];
        r_even = ~t_r[0];

        n_hp = (c_even || r_col == '0) ? s_ext : r_hp + s_ext;

        a_ok   = c_even && ow1 != '0 && ((CW+1)'(ow1) <= ow_lim);
        b_ok   = (r_col == w_last) && ((CW+1)'(ow1) < ow_lim);
        oh0_ok = r_even && oh1 != '0 && ((RW+1)'(oh1) <= oh_lim);
        oh1_ok = (RW+1)'(oh1) < oh_lim;

        oh1_first = r_even || r_row == '0;
        oh1_emit  = r_row == h_last;

        done_ra = (RW+1)'(oh1) == oh_lim;
        done_rb = (RW+1)'(oh1) + (RW+1)'(1) == oh_lim;
        done_ca = (CW+1)'(ow1) == ow_lim;
        done_cb = (CW+1)'(ow1) + (CW+1)'(1) == ow_lim;

        o_slots.valid = {oh1_ok & b_ok, oh1_ok & a_ok, oh0_ok & b_ok, oh0_ok & a_ok};
        o_slots.emit  = o_slots.valid & {oh1_emit, oh1_emit, 1'b1, 1'b1};
        o_slots.first = o_slots.valid & {oh1_first, oh1_first, 1'b0, 1'b0};
        o_slots.done  = o_slots.emit & {done_rb & done_cb, done_rb & done_ca,
                                        done_ra & done_cb, done_ra & done_ca};
        em = o_slots.emit;
        o_slots.last  = {em[3], em[2] & ~em[3], em[1] & ~|em[3:2], em[0] & ~|em[3:1]};
        o_slots.bank0 = ~oh1[0];

        o_seg_a    = r_hp + s_ext;
        o_seg_b    = n_hp;
        o_ow_b     = ow1[AW-1:0];
        o_rec_push = i_accept && |o_slots.valid;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (r_col >= w_last) begin
                n_col = '0;
                n_row = (r_row >= h_last) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_hp  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_accept) begin
                r_hp <= n_hp;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/avgp_back.sv =====
// back end: window update sequencer, accumulator memory, divide by nine
// depends on avgp_pkg, avgp_queue, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module avgp_back #(
    parameter int MAX_WIDTH   = avgp_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rec_valid,
    input  avgp_pkg::t_slots                      i_slots,
    input  logic signed [SAMPLE_BITS+1:0]         i_seg_a,
    input  logic signed [SAMPLE_BITS+1:0]         i_seg_b,
    input  logic [$clog2(MAX_WIDTH/2+1)-1:0]      i_ow_b,
    output logic                                  o_rec_pop,
    output logic                                  o_empty,
    input  logic                                  i_pop,
    output logic signed [SAMPLE_BITS-1:0]         o_average,
    output logic                                  o_plane_done,
    output logic                                  o_run_last
);
    import avgp_pkg::*;

    localparam int ACC_COLS = MAX_WIDTH / 2 + 1;
    localparam int AW       = $clog2(ACC_COLS);
    localparam int MIW      = $clog2(2 * ACC_COLS);
    localparam int HW       = SAMPLE_BITS + 2;
    localparam int ACW      = SAMPLE_BITS + 4;
    localparam int OCW      = $clog2(OUT_DEPTH + 1);
    localparam logic [ACW-1:0] RECIP = ACW'((64'd1 << ACW) / 64'd9);

    // current record
    logic [NUM_SLOTS-1:0] r_mask, n_mask, w_onehot;
    t_slots               r_slots;
    logic signed [HW-1:0] r_seg_a, r_seg_b;
    logic [AW-1:0]        r_ow_b;
    logic [1:0]           w_k;
    logic                 w_issue, w_credit;
    logic [OCW:0]         w_occ;
    logic [OCW-1:0]       w_out_cnt;

    // issue fields
    logic                 w_bank;
    logic [AW-1:0]        w_addr;
    logic [MIW-1:0]       w_idx;

    // accumulate stage
    logic                  r_s1_v, r_s1_first, r_s1_emit, r_s1_done, r_s1_last;
    logic [MIW-1:0]        r_s1_idx;
    logic signed [HW-1:0]  r_s1_seg;
    logic signed [ACW-1:0] r_rd, w_rd_eff, w_sum;
    logic signed [ACW-1:0] r_mem [2*ACC_COLS];
    logic                  r_wr_v;
    logic [MIW-1:0]        r_wr_idx;
    logic signed [ACW-1:0] r_wr_data;

    // divide stages
    logic                  r_s2_v, r_s2_done, r_s2_last;
    logic signed [ACW-1:0] r_s2_sum;
    logic [ACW-1:0]        w_mag, w_y;
    logic                  r_s3_v, r_s3_neg, r_s3_done, r_s3_last;
    logic [ACW-1:0]        r_s3_y;
    logic [2*ACW-1:0]      r_s3_prod;
    logic [ACW-1:0]        w_qe, w_q;
    logic [ACW+3:0]        w_rem;
    logic [ACW-1:0]        w_res;
    logic                  w_full;
    logic [SAMPLE_BITS+1:0] w_out_word;

    always_comb begin
        priority if (r_mask[0]) begin
            w_k = 2'd0;
        end else if (r_mask[1]) begin
            w_k = 2'd1;
        end else if (r_mask[2]) begin
            w_k = 2'd2;
        end else begin
            w_k = 2'd3;
        end
        w_onehot = NUM_SLOTS'(1) << w_k;
        w_occ    = {1'b0, w_out_cnt} + (OCW+1)'(r_s1_v) + (OCW+1)'(r_s2_v)
                 + (OCW+1)'(r_s3_v);
        w_credit = w_occ < (OCW+1)'(OUT_DEPTH);
        w_issue  = |r_mask && w_credit;
        n_mask   = w_issue ? (r_mask & ~w_onehot) : r_mask;
        o_rec_pop = (n_mask == '0) && i_rec_valid;

        w_bank = w_k[1] ? ~r_slots.bank0 : r_slots.bank0;
        w_addr = w_k[0] ? r_ow_b : r_ow_b - AW'(1);
        w_idx  = (w_bank ? MIW'(ACC_COLS) : MIW'(0)) + MIW'(w_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= o_rec_pop ? i_slots.valid : n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_slots <= i_slots;
            r_seg_a <= i_seg_a;
            r_seg_b <= i_seg_b;
            r_ow_b  <= i_ow_b;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_idx   <= w_idx;
            r_s1_seg   <= w_k[0] ? r_seg_b : r_seg_a;
            r_s1_first <= r_slots.first[w_k];
            r_s1_emit  <= r_slots.emit[w_k];
            r_s1_done  <= r_slots.done[w_k];
            r_s1_last  <= r_slots.last[w_k];
            r_rd       <= r_mem[w_idx];
        end
    end

    // accumulate with forwarding of the previous write
    always_comb begin
        w_rd_eff = (r_wr_v && r_wr_idx == r_s1_idx) ? r_wr_data : r_rd;
        w_sum    = r_s1_first ? ACW'(r_s1_seg) : w_rd_eff + ACW'(r_s1_seg);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_mem[r_s1_idx] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_wr_v <= r_s1_v;
            r_s2_v <= r_s1_v && r_s1_emit;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_idx  <= r_s1_idx;
        r_wr_data <= w_sum;
        r_s2_sum  <= w_sum;
        r_s2_done <= r_s1_done;
        r_s2_last <= r_s1_last;
    end

    // rounded divide by nine: reciprocal product then one correction
    always_comb begin
        w_mag = r_s2_sum[ACW-1] ? ACW'(-r_s2_sum) : ACW'(r_s2_sum);
        w_y   = w_mag + ACW'(4);
    end

    always_ff @(posedge i_clk) begin
        r_s3_y    <= w_y;
        r_s3_prod <= (2*ACW)'(w_y) * (2*ACW)'(RECIP);
        r_s3_neg  <= r_s2_sum[ACW-1];
        r_s3_done <= r_s2_done;
        r_s3_last <= r_s2_last;
    end

    always_comb begin
        w_qe  = r_s3_prod[2*ACW-1:ACW];
        w_rem = (ACW+4)'(r_s3_y) - ((ACW+4)'(w_qe) << 3) - (ACW+4)'(w_qe);
        w_q   = (w_rem >= (ACW+4)'(9)) ? w_qe + ACW'(1) : w_qe;
        w_res = r_s3_neg ? (ACW'(0) - w_q) : w_q;
        w_out_word = {w_res[SAMPLE_BITS-1:0], r_s3_done, r_s3_last};
    end

    logic [SAMPLE_BITS+1:0] w_head;

    avgp_queue #(
        .WIDTH (SAMPLE_BITS + 2),
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_v),
        .i_data  (w_out_word),
        .o_full  (w_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (w_head),
        .o_count (w_out_cnt)
    );

    assign o_average    = w_head[SAMPLE_BITS+1:2];
    assign o_plane_done = w_head[1];
    assign o_run_last   = w_head[0];

    `AVGP_ASSERT_ALWAYS(a_credit, w_occ <= (OCW+1)'(OUT_DEPTH), "result words over credit")
    `AVGP_ASSERT_ALWAYS(a_no_drop, !(r_s3_v && w_full), "result lost at full queue")
    `AVGP_ASSERT_NEXT(a_emit_path, r_s1_v && r_s1_emit, r_s2_v, "emitted window lost")
    `AVGP_ASSERT_ALWAYS(a_last_emit, !(r_s1_v && r_s1_last && !r_s1_emit), "last on silent slot")

endmodule

`default_nettype wire
